FILE: rtl/tsdf_pkg.sv
// Shared types, character codes and helpers for the text stream display filter.
package tsdf_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_ALL      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_NONBLANK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_ENDS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK   = 3'd5;

    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_DOLLAR = 8'd36;
    localparam logic [7:0] CH_DASH   = 8'd45;
    localparam logic [7:0] CH_QMARK  = 8'd63;
    localparam logic [7:0] CH_I      = 8'd73;
    localparam logic [7:0] CH_M      = 8'd77;
    localparam logic [7:0] CH_CARET  = 8'd94;
    localparam logic [7:0] CH_DEL    = 8'd127;
    localparam logic [7:0] CH_HIGH   = 8'd160;
    localparam logic [7:0] CH_MAX    = 8'd255;
    localparam logic [7:0] CH_CTRL_END = 8'd32;
    localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

    localparam logic [23:0] BCD_ONE = 24'h000001;
    localparam logic [23:0] BCD_MAX = 24'h999999;

    typedef logic [3:0] t_pos;
    localparam t_pos POS_FIRST_DIGIT = 4'd0;
    localparam t_pos POS_LAST_DIGIT  = 4'd5;
    localparam t_pos POS_TAB         = 4'd6;
    localparam t_pos POS_DOLLAR      = 4'd7;
    localparam t_pos POS_TAIL        = 4'd8;

    typedef struct packed {
        logic number_all;
        logic number_nonblank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprint;
        logic squeeze_blank;
    } t_cfg;

    typedef struct packed {
        logic            num_en;
        logic [23:0]     bcd;
        logic            dollar;
        logic [3:0][7:0] tail;
        logic [1:0]      tail_last;
    } t_desc;

    function automatic logic [23:0] bcd_inc(input logic [23:0] v);
        logic [23:0] res;
        logic        carry;
        logic [4:0]  sum;
        res   = '0;
        carry = 1'b1;
        for (int d = 0; d < 6; d++) begin
            sum = {1'b0, v[d*4 +: 4]} + {4'd0, carry};
            if (sum >= 5'd10) begin
                res[d*4 +: 4] = 4'd0;
                carry         = 1'b1;
            end else begin
                res[d*4 +: 4] = sum[3:0];
                carry         = 1'b0;
            end
        end
        return res;
    endfunction

endpackage

FILE: rtl/text_stream_display_filter.sv
// Top level of the text stream display filter: config registers, front, queue, back.
//
//  channel   dir  handshake                     payload (lsb first)
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: in_byte; tuser: file_start
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: out_byte; tlast: last
//  cfg       in   i_cfg_we (no wait)            i_cfg_idx register, i_cfg_data value
//
//  The front takes one input byte per cycle while the queue has room.
//  The back sends one display byte per cycle unless stalled, 1 to 11 per input byte;
//  sustained rate is set by the number of display bytes an input expands to.
//  A squeezed newline is dropped in the front and never reaches the queue.
//  Synchronous active-low reset; an output stall backs up into the queue.
module text_stream_display_filter import tsdf_pkg::*; #(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] in_byte
    input  logic                 s_axis_tuser,   // [0] file_start
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [7:0] out_byte
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [0:0]           i_cfg_data
);

    t_cfg  r_cfg;
    logic  push;
    logic  q_full;
    logic  pop;
    logic  head_valid;
    t_desc push_desc;
    t_desc head_desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NUMBER_ALL:      r_cfg.number_all      <= i_cfg_data[0];
                REG_NUMBER_NONBLANK: r_cfg.number_nonblank <= i_cfg_data[0];
                REG_SHOW_ENDS:       r_cfg.show_ends       <= i_cfg_data[0];
                REG_SHOW_TABS:       r_cfg.show_tabs       <= i_cfg_data[0];
                REG_SHOW_NONPRINT:   r_cfg.show_nonprint   <= i_cfg_data[0];
                REG_SQUEEZE_BLANK:   r_cfg.squeeze_blank   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    tsdf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_byte       (s_axis_tdata),
        .i_file_start (s_axis_tuser),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_desc       (push_desc)
    );

    tsdf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_desc  (head_desc)
    );

    tsdf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_desc),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_byte       (m_axis_tdata),
        .o_last       (m_axis_tlast)
    );

endmodule

FILE: rtl/tsdf_front.sv
// Front end: line state, blank squeezing, line counter and byte classification.
module tsdf_front import tsdf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte,
    input  logic        i_file_start,
    input  logic        i_q_full,
    output logic        o_push,
    output t_desc       o_desc
);

    logic        r_prev_nl;
    logic        r_blank_run;
    logic [23:0] r_bcd;

    logic        n_prev_nl;
    logic        n_blank_run;
    logic [23:0] n_bcd;

    logic        accept;
    logic        prev_nl;
    logic        blank_run;
    logic        is_nl;
    logic        squeeze;
    logic        number;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;

    always_comb begin
        prev_nl   = i_file_start ? 1'b1 : r_prev_nl;
        blank_run = i_file_start ? 1'b0 : r_blank_run;
        is_nl     = (i_byte == CH_NL);
        squeeze   = is_nl && prev_nl && blank_run && i_cfg.squeeze_blank;
        number    = prev_nl && (i_cfg.number_nonblank ? !is_nl : i_cfg.number_all);

        o_desc.num_en    = number;
        o_desc.bcd       = r_bcd;
        o_desc.dollar    = is_nl && i_cfg.show_ends;
        o_desc.tail      = '0;
        o_desc.tail[0]   = i_byte;
        o_desc.tail_last = 2'd0;

        if (i_byte == CH_TAB) begin
            if (i_cfg.show_tabs) begin
                o_desc.tail[0]   = CH_CARET;
                o_desc.tail[1]   = CH_I;
                o_desc.tail_last = 2'd1;
            end
        end else if (i_cfg.show_nonprint && !is_nl) begin
            if (i_byte < CH_CTRL_END) begin
                o_desc.tail[0]   = CH_CARET;
                o_desc.tail[1]   = i_byte + 8'd64;
                o_desc.tail_last = 2'd1;
            end else if (i_byte == CH_DEL) begin
                o_desc.tail[0]   = CH_CARET;
                o_desc.tail[1]   = CH_QMARK;
                o_desc.tail_last = 2'd1;
            end else if (i_byte == CH_MAX) begin
                o_desc.tail[0]   = CH_M;
                o_desc.tail[1]   = CH_DASH;
                o_desc.tail[2]   = CH_CARET;
                o_desc.tail[3]   = CH_QMARK;
                o_desc.tail_last = 2'd3;
            end else if (i_byte >= CH_HIGH) begin
                o_desc.tail[0]   = CH_M;
                o_desc.tail[1]   = CH_DASH;
                o_desc.tail[2]   = i_byte - 8'd128;
                o_desc.tail_last = 2'd2;
            end else if (i_byte[7]) begin
                o_desc.tail[0]   = CH_M;
                o_desc.tail[1]   = CH_DASH;
                o_desc.tail[2]   = CH_CARET;
                o_desc.tail[3]   = i_byte - 8'd64;
                o_desc.tail_last = 2'd3;
            end
        end

        n_prev_nl   = r_prev_nl;
        n_blank_run = r_blank_run;
        n_bcd       = r_bcd;
        if (accept && !squeeze) begin
            n_prev_nl   = is_nl;
            n_blank_run = is_nl && prev_nl;
            if (number && (r_bcd != BCD_MAX)) begin
                n_bcd = bcd_inc(r_bcd);
            end
        end
        o_push = accept && !squeeze;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_nl   <= 1'b1;
            r_blank_run <= 1'b0;
            r_bcd       <= BCD_ONE;
        end else begin
            r_prev_nl   <= n_prev_nl;
            r_blank_run <= n_blank_run;
            r_bcd       <= n_bcd;
        end
    end

`ifndef ASSERT_OFF
    a_counter_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bcd != '0)
        else $error("line counter reached zero");
`endif

endmodule

FILE: rtl/tsdf_fifo.sv
// Short descriptor queue between front and back end.
module tsdf_fifo import tsdf_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_desc o_desc
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_desc            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
`endif

endmodule

FILE: rtl/tsdf_back.sv
// Back end: serialize one descriptor into display bytes through an output register.
module tsdf_back import tsdf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_valid,
    input  t_desc      i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last
);

    logic       r_busy;
    t_pos       r_pos;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    logic            load;
    t_pos            pos;
    t_pos            n_pos;
    logic [7:0]      byte_sel;
    logic            last;
    logic [5:0][3:0] digits;
    logic [5:0]      zero_from;
    logic [2:0]      k;
    logic [1:0]      tail_idx;

    always_comb begin
        digits = i_head.bcd;
        zero_from[5] = (digits[5] == 4'd0);
        for (int j = 4; j >= 0; j--) begin
            zero_from[j] = zero_from[j+1] && (digits[j] == 4'd0);
        end

        if (r_busy) begin
            pos = r_pos;
        end else if (i_head.num_en) begin
            pos = POS_FIRST_DIGIT;
        end else if (i_head.dollar) begin
            pos = POS_DOLLAR;
        end else begin
            pos = POS_TAIL;
        end

        k        = 3'(POS_LAST_DIGIT) - pos[2:0];
        tail_idx = 2'(pos - POS_TAIL);

        if (pos <= POS_LAST_DIGIT) begin
            byte_sel = (zero_from[k] && (k != 3'd0)) ? CH_SPACE : {ASCII_DIGIT_HI, digits[k]};
        end else if (pos == POS_TAB) begin
            byte_sel = CH_TAB;
        end else if (pos == POS_DOLLAR) begin
            byte_sel = CH_DOLLAR;
        end else begin
            byte_sel = i_head.tail[tail_idx];
        end

        last  = (pos >= POS_TAIL) && (tail_idx == i_head.tail_last);
        n_pos = ((pos == POS_TAB) && !i_head.dollar) ? POS_TAIL : pos + 1'b1;

        load  = i_head_valid && (!r_valid || i_ready);
        o_pop = load && last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pos   <= POS_FIRST_DIGIT;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_busy  <= !last;
                r_pos   <= n_pos;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= byte_sel;
            r_last <= last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

`ifndef ASSERT_OFF
    a_busy_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> i_head_valid)
        else $error("descriptor left queue mid-run");
`endif

endmodule

FILE: test/tsdf_display_checker.sv
`timescale 1ns / 100ps
// Checker for the text stream display filter: predicts every display byte and compares.
module tsdf_display_checker import tsdf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_valid,
    input  logic                 i_s_ready,
    input  logic [7:0]           i_s_data,   // [7:0] in_byte
    input  logic                 i_s_user,   // [0] file_start
    input  logic                 i_m_valid,
    input  logic                 i_m_ready,
    input  logic [7:0]           i_m_data,   // [7:0] out_byte
    input  logic                 i_m_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [0:0]           i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_squeezed
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_disp;

    t_disp       expected_display[$];
    t_cfg        opts;
    logic        at_line_start;
    logic        blank_run;
    logic [23:0] line_bcd;
    int          fail_total;
    int          checked_total;
    int          squeezed_total;
    int          pending_total;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;
    assign o_checked    = checked_total;
    assign o_squeezed   = squeezed_total;

    function automatic void render_byte(input logic [7:0] raw, input logic first);
        logic [7:0] c;
        logic [7:0] outs[$];
        logic [3:0] digit;
        logic       lead;
        logic       carry;
        logic       want_num;
        t_disp      item;
        c = raw;
        if (first) begin
            at_line_start = 1'b1;
            blank_run     = 1'b0;
        end
        if (c == CH_NL && at_line_start) begin
            if (blank_run && opts.squeeze_blank) begin
                squeezed_total++;
                return;
            end
            blank_run = 1'b1;
        end else begin
            blank_run = 1'b0;
        end
        want_num = at_line_start &&
                   (opts.number_nonblank ? (c != CH_NL) : opts.number_all);
        if (want_num) begin
            lead = 1'b1;
            for (int d = 5; d >= 0; d--) begin
                digit = line_bcd[d*4 +: 4];
                if (digit != 4'd0 || d == 0)
                    lead = 1'b0;
                outs.push_back(lead ? CH_SPACE : {ASCII_DIGIT_HI, digit});
            end
            outs.push_back(CH_TAB);
            if (line_bcd != BCD_MAX) begin
                carry = 1'b1;
                for (int d = 0; d < 6; d++) begin
                    if (carry) begin
                        if (line_bcd[d*4 +: 4] == 4'd9) begin
                            line_bcd[d*4 +: 4] = 4'd0;
                        end else begin
                            line_bcd[d*4 +: 4] = line_bcd[d*4 +: 4] + 4'd1;
                            carry = 1'b0;
                        end
                    end
                end
            end
        end
        if (c == CH_NL && opts.show_ends)
            outs.push_back(CH_DOLLAR);
        if (c == CH_TAB && opts.show_tabs) begin
            outs.push_back(CH_CARET);
            c = CH_I;
        end
        if (opts.show_nonprint) begin
            if (c < CH_CTRL_END && c != CH_NL && c != CH_TAB) begin
                outs.push_back(CH_CARET);
                c = c + 8'd64;
            end else if (c > CH_DEL && c < CH_HIGH) begin
                outs.push_back(CH_M);
                outs.push_back(CH_DASH);
                outs.push_back(CH_CARET);
                c = c - 8'd64;
            end else if (c >= CH_HIGH) begin
                outs.push_back(CH_M);
                outs.push_back(CH_DASH);
                c = c - 8'd128;
            end
        end
        if (c == CH_DEL && opts.show_nonprint) begin
            outs.push_back(CH_CARET);
            outs.push_back(CH_QMARK);
        end else begin
            outs.push_back(c);
        end
        at_line_start = (c == CH_NL);
        foreach (outs[i]) begin
            item.ch   = outs[i];
            item.last = (i == outs.size() - 1);
            expected_display.push_back(item);
        end
    endfunction

    always @(posedge i_clk) begin
        t_disp want;
        if (!i_rst_n) begin
            opts           = '0;
            at_line_start  = 1'b1;
            blank_run      = 1'b0;
            line_bcd       = BCD_ONE;
            fail_total     = 0;
            checked_total  = 0;
            squeezed_total = 0;
            expected_display.delete();
            pending_total  = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_NUMBER_ALL:      opts.number_all      = i_cfg_data[0];
                    REG_NUMBER_NONBLANK: opts.number_nonblank = i_cfg_data[0];
                    REG_SHOW_ENDS:       opts.show_ends       = i_cfg_data[0];
                    REG_SHOW_TABS:       opts.show_tabs       = i_cfg_data[0];
                    REG_SHOW_NONPRINT:   opts.show_nonprint   = i_cfg_data[0];
                    REG_SQUEEZE_BLANK:   opts.squeeze_blank   = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_valid && i_s_ready)
                render_byte(i_s_data, i_s_user);
            if (i_m_valid && i_m_ready) begin
                if (expected_display.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected display byte %02h last %0b",
                             $time, i_m_data, i_m_last);
                end else begin
                    want = expected_display.pop_front();
                    checked_total++;
                    if (i_m_data !== want.ch) begin
                        fail_total++;
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, want.ch, i_m_data);
                    end
                    if (i_m_last !== want.last) begin
                        fail_total++;
                        $display("%0t: last expected %0b actual %0b",
                                 $time, want.last, i_m_last);
                    end
                end
            end
            pending_total = expected_display.size();
        end
    end

endmodule

FILE: test/tb_text_stream_display_filter.sv
`timescale 1ns / 100ps
// Testbench top for the text stream display filter: stimulus, options, stalls and verdict.
module tb_text_stream_display_filter;
    import tsdf_pkg::*;

    localparam int SETTLE_CYCLES = 20;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_BYTES   = 33;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;   // [7:0] in_byte
    logic                 s_axis_tuser;   // [0] file_start
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;   // [7:0] out_byte
    logic                 m_axis_tlast;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [0:0]           i_cfg_data;

    logic s_fire = 1'b0;
    logic in_idle_en = 1'b0;
    logic out_stall_en = 1'b0;
    int   fail_count;
    int   pending;
    int   checked;
    int   squeezed;
    int   bytes_sent = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    text_stream_display_filter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    tsdf_display_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_axis_tvalid),
        .i_s_ready    (s_axis_tready),
        .i_s_data     (s_axis_tdata),
        .i_s_user     (s_axis_tuser),
        .i_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .i_m_data     (m_axis_tdata),
        .i_m_last     (m_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_squeezed   (squeezed)
    );

    always @(posedge i_clk)
        s_fire <= s_axis_tvalid && s_axis_tready;

    function automatic int stall_cycles();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] next_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return CH_NL;
        if (r < 32)
            return CH_TAB;
        if (r < 75)
            return 8'($urandom_range(32, 126));
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (out_stall_en && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall_cycles()) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic first);
        int gap;
        gap = (in_idle_en && $urandom_range(0, 2) == 0) ? stall_cycles() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= first;
        do @(negedge i_clk); while (!s_fire);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
    endtask

    task automatic set_options(input t_cfg c);
        write_reg(REG_NUMBER_ALL, c.number_all);
        write_reg(REG_NUMBER_NONBLANK, c.number_nonblank);
        write_reg(REG_SHOW_ENDS, c.show_ends);
        write_reg(REG_SHOW_TABS, c.show_tabs);
        write_reg(REG_SHOW_NONPRINT, c.show_nonprint);
        write_reg(REG_SQUEEZE_BLANK, c.squeeze_blank);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic [7:0] dir_bytes[$];
        logic       dir_first[$];
        t_cfg       c;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_NUMBER_ALL;
        i_cfg_data    = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        dir_bytes = '{8'h41, 8'h00, CH_TAB, 8'h1f, CH_DEL, 8'h80, 8'h9f, CH_HIGH,
                      CH_MAX, 8'h7e, CH_NL, CH_NL, CH_NL, CH_NL, CH_SPACE, CH_NL,
                      CH_NL, CH_NL, CH_NL, 8'h8a, CH_TAB, CH_NL, CH_NL, CH_NL};
        dir_first = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                      1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: c = '1;
                1: c = '0;
                2: c = '{number_all: 1'b1, number_nonblank: 1'b0, show_ends: 1'b1,
                         show_tabs: 1'b0, show_nonprint: 1'b0, squeeze_blank: 1'b1};
                default: c = t_cfg'(6'($urandom_range(0, 63)));
            endcase
            set_options(c);
            in_idle_en   = (p != 1) && ($urandom_range(0, 3) != 0);
            out_stall_en = (p != 1) && ($urandom_range(0, 3) != 0);
            if (p == 0 || p == 1) begin
                foreach (dir_bytes[i])
                    send_byte(dir_bytes[i], dir_first[i]);
            end
            for (int i = 0; i < PHASE_BYTES; i++)
                send_byte(next_text_byte(), $urandom_range(0, 29) == 0);
            drain();
        end

        $display("Ran %0d input bytes under %0d option sets with random gaps and stalls;",
                 bytes_sent, NUM_PHASES);
        $display("%0d display bytes checked, %0d newlines squeezed.", checked, squeezed);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
